/* hdl/lens_undistort_point_iterative_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the lens undistortion block
// Clocked, reset-qualified concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef LENS_UNDISTORT_POINT_ITERATIVE_DEFINES_SVH
`define LENS_UNDISTORT_POINT_ITERATIVE_DEFINES_SVH

// generic form: explicit clock and active-low reset
`define LUIP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// house clock and reset names
`define LUIP_ASSERT_CK(lbl, prop, msg) `LUIP_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

/* hdl/luip_pkg.sv */
// ----------------------------------------------------------------------------
// luip_pkg
// Types, register codes and fixed point helpers for lens undistortion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package luip_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_FOCAL_X = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FOCAL_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_X = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_Y = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RADIAL_K1 = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_RADIAL_K2 = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_TAN_P1 = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_TAN_P2 = 3'd7;

  localparam int MAX_ITERATIONS_DEF = 100;
  localparam int IMAGE_WIDTH_DEF    = 640;
  localparam int IMAGE_HEIGHT_DEF   = 480;
  localparam logic signed [31:0] RADIAL_K3_DEF = 32'sd0;

  localparam int DivW   = 16;   // focal length width
  localparam int RecipW = 41;   // floor(2^40 / f)
  localparam int MulW   = 33;   // shared multiplier operand width
  localparam int ProdW  = 66;

  localparam logic signed [31:0] QOne  = 32'sh1000_0000;
  localparam logic [43:0]        EpsQ8 = 44'd64;

  typedef struct packed {
    logic [15:0] distorted_x;
    logic [15:0] distorted_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0] corrected_x;
    logic [15:0] corrected_y;
    logic        converged;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    return sat32({{32{v[33]}}, v});
  endfunction

  // Q4.28 product: floor shift then saturate
  function automatic logic signed [31:0] mulq(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] s;
    s = p >>> 28;
    return sat32(s);
  endfunction

endpackage

/* hdl/luip_stream_if.sv */
// ----------------------------------------------------------------------------
// luip_stream_if
// Valid/ready channel carrying one word of a packed payload type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface luip_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hdl/lens_undistort_point_iterative.sv */
// ----------------------------------------------------------------------------
// lens_undistort_point_iterative
// Takes one distorted pixel (Q12.4) and returns the undistorted pixel found
// by fixed point iteration of the Brown-Conrady model, clamped to the image,
// with a converged flag. One point is in flight at a time: after a word is
// accepted the two reciprocal dividers run, then each pass runs on the single
// shared 33x33 multiplier (one product issued a cycle, written back the next).
// A point takes between 1 and MAX_ITERATIONS passes, ending early once it has
// converged. The result sits in an output register, so the next point is taken
// while it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lens_undistort_point_iterative #(
  parameter int                 MAX_ITERATIONS = luip_pkg::MAX_ITERATIONS_DEF,
  parameter int                 IMAGE_WIDTH    = luip_pkg::IMAGE_WIDTH_DEF,
  parameter int                 IMAGE_HEIGHT   = luip_pkg::IMAGE_HEIGHT_DEF,
  parameter logic signed [31:0] RADIAL_K3      = luip_pkg::RADIAL_K3_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [luip_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [luip_pkg::CfgDataW-1:0]     cfg_data_i,
  luip_stream_if.sink                       in_i,
  luip_stream_if.source                     out_o
);

  localparam int PassW = $clog2(MAX_ITERATIONS + 1);
  localparam logic signed [20:0] XMax = 21'((IMAGE_WIDTH - 1) * 16);
  localparam logic signed [20:0] YMax = 21'((IMAGE_HEIGHT - 1) * 16);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PASS = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [4:0] ST_NX_LO = 5'd0;
  localparam logic [4:0] ST_NX_HI = 5'd1;
  localparam logic [4:0] ST_NY_LO = 5'd2;
  localparam logic [4:0] ST_NY_HI = 5'd3;
  localparam logic [4:0] ST_X2    = 5'd4;
  localparam logic [4:0] ST_Y2    = 5'd5;
  localparam logic [4:0] ST_XY    = 5'd6;
  localparam logic [4:0] ST_R4    = 5'd7;
  localparam logic [4:0] ST_K1    = 5'd8;
  localparam logic [4:0] ST_R6    = 5'd9;
  localparam logic [4:0] ST_K2    = 5'd10;
  localparam logic [4:0] ST_K3    = 5'd11;
  localparam logic [4:0] ST_XP1   = 5'd12;
  localparam logic [4:0] ST_XT    = 5'd13;
  localparam logic [4:0] ST_XP2   = 5'd14;
  localparam logic [4:0] ST_YP2   = 5'd15;
  localparam logic [4:0] ST_YT    = 5'd16;
  localparam logic [4:0] ST_YP1   = 5'd17;
  localparam logic [4:0] ST_DU    = 5'd18;
  localparam logic [4:0] ST_DV    = 5'd19;
  localparam logic [4:0] ST_EX2   = 5'd20;
  localparam logic [4:0] ST_EY2   = 5'd21;
  localparam logic [4:0] ST_CHECK = 5'd22;

  // configuration
  logic [15:0]        fx_q, fy_q, cx_q, cy_q;
  logic signed [31:0] k1_q, k2_q, p1_q, p2_q;

  // control
  logic [1:0]         state_q;
  logic [4:0]         step_q;
  logic [PassW-1:0]   pass_q;
  logic               out_valid_q;
  logic               div_start;
  logic               div_x_done, div_y_done;

  // datapath
  logic [15:0]        in_u_q, in_v_q;
  logic [15:0]        fxe, fye;
  logic [luip_pkg::RecipW-1:0] rx, ry;
  logic signed [20:0] gu_q, gv_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] x_q, y_q, x2_q, y2_q, txy_q, r2_q, r4_q, r6_q, t_q, xd_q, yd_q;
  logic signed [33:0] sum_q;
  logic signed [21:0] ex_q, ey_q;
  logic [43:0]        exsq_q;
  logic               conv_q;
  luip_pkg::out_item_t out_q;

  logic signed [luip_pkg::MulW-1:0]  mul_a, mul_b;
  logic signed [luip_pkg::ProdW-1:0] prod;

  logic signed [22:0] dx, dy;
  logic signed [31:0] mq, sx, sy, norm;
  logic signed [63:0] nsum, nsh;
  logic signed [luip_pkg::ProdW-1:0] pshr;
  logic signed [23:0] dpix, res, gnew;
  logic signed [21:0] res_c;
  logic signed [20:0] g_old, g_c;
  logic [15:0]        c_sel, in_sel;
  logic [43:0]        err;
  logic               conv;
  logic [15:0]        ox, oy;

  assign fxe = (fx_q == '0) ? 16'd1 : fx_q;
  assign fye = (fy_q == '0) ? 16'd1 : fy_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign div_start  = in_i.valid && in_i.ready;

  luip_recip u_recip_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .divisor_i(fxe),
    .done_o   (div_x_done),
    .quot_o   (rx)
  );

  luip_recip u_recip_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .divisor_i(fye),
    .done_o   (div_y_done),
    .quot_o   (ry)
  );

  luip_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  // operand select for the product issued this cycle
  always_comb begin
    dx = $signed({{2{gu_q[20]}}, gu_q}) - $signed({7'b0, cx_q});
    dy = $signed({{2{gv_q[20]}}, gv_q}) - $signed({7'b0, cy_q});
    sx = luip_pkg::sat34(luip_pkg::sx34(r2_q) + (luip_pkg::sx34(x2_q) <<< 1));
    sy = luip_pkg::sat34(luip_pkg::sx34(r2_q) + (luip_pkg::sx34(y2_q) <<< 1));
    mul_a = '0;
    mul_b = '0;
    unique case (step_q)
      ST_NX_LO: begin
        mul_a = {{10{dx[22]}}, dx};
        mul_b = {13'b0, rx[19:0]};
      end
      ST_NX_HI: begin
        mul_a = {{10{dx[22]}}, dx};
        mul_b = {12'b0, rx[40:20]};
      end
      ST_NY_LO: begin
        mul_a = {{10{dy[22]}}, dy};
        mul_b = {13'b0, ry[19:0]};
      end
      ST_NY_HI: begin
        mul_a = {{10{dy[22]}}, dy};
        mul_b = {12'b0, ry[40:20]};
      end
      ST_X2:  begin mul_a = {x_q[31], x_q};     mul_b = {x_q[31], x_q};     end
      ST_Y2:  begin mul_a = {y_q[31], y_q};     mul_b = {y_q[31], y_q};     end
      ST_XY:  begin mul_a = {x_q[31], x_q};     mul_b = {y_q[31], y_q};     end
      ST_R4:  begin mul_a = {r2_q[31], r2_q};   mul_b = {r2_q[31], r2_q};   end
      ST_K1:  begin mul_a = {k1_q[31], k1_q};   mul_b = {r2_q[31], r2_q};   end
      ST_R6:  begin mul_a = {r4_q[31], r4_q};   mul_b = {r2_q[31], r2_q};   end
      ST_K2:  begin mul_a = {k2_q[31], k2_q};   mul_b = {r4_q[31], r4_q};   end
      ST_K3:  begin mul_a = {RADIAL_K3[31], RADIAL_K3}; mul_b = {r6_q[31], r6_q}; end
      ST_XP1: begin mul_a = {txy_q[31], txy_q}; mul_b = {p1_q[31], p1_q};   end
      ST_XT:  begin mul_a = {x_q[31], x_q};     mul_b = {t_q[31], t_q};     end
      ST_XP2: begin mul_a = {p2_q[31], p2_q};   mul_b = {sx[31], sx};       end
      ST_YP2: begin mul_a = {txy_q[31], txy_q}; mul_b = {p2_q[31], p2_q};   end
      ST_YT:  begin mul_a = {y_q[31], y_q};     mul_b = {t_q[31], t_q};     end
      ST_YP1: begin mul_a = {p1_q[31], p1_q};   mul_b = {sy[31], sy};       end
      ST_DU:  begin mul_a = {xd_q[31], xd_q};   mul_b = {17'b0, fxe};       end
      ST_DV:  begin mul_a = {yd_q[31], yd_q};   mul_b = {17'b0, fye};       end
      ST_EX2: begin mul_a = {{11{ex_q[21]}}, ex_q}; mul_b = {{11{ex_q[21]}}, ex_q}; end
      ST_EY2: begin mul_a = {{11{ey_q[21]}}, ey_q}; mul_b = {{11{ey_q[21]}}, ey_q}; end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // write-back helpers for the product issued last cycle
  always_comb begin
    mq   = luip_pkg::mulq(prod);
    // exact 64-bit value of diff * recip: low half plus high half << 20
    nsum = acc_q + (prod[63:0] <<< 20);
    nsh  = nsum >>> 12;
    norm = luip_pkg::sat32({{2{nsh[63]}}, nsh});
    pshr = prod >>> 28;
    c_sel  = (step_q == ST_DV) ? cx_q : cy_q;
    in_sel = (step_q == ST_DV) ? in_u_q : in_v_q;
    g_old  = (step_q == ST_DV) ? gu_q : gv_q;
    dpix = pshr[23:0] + $signed({8'b0, c_sel});
    res  = $signed({8'b0, in_sel}) - dpix;
    if (res > 24'sh1F_FFFF) begin
      res_c = 22'sh1F_FFFF;
    end else if (res < -24'sh20_0000) begin
      res_c = -22'sh20_0000;
    end else begin
      res_c = res[21:0];
    end
    gnew = $signed({{3{g_old[20]}}, g_old}) + $signed({{2{res_c[21]}}, res_c});
    if (gnew > 24'sh0F_FFFF) begin
      g_c = 21'sh0F_FFFF;
    end else if (gnew < -24'sh10_0000) begin
      g_c = -21'sh10_0000;
    end else begin
      g_c = gnew[20:0];
    end
    err  = exsq_q + prod[43:0];
    conv = (err <= luip_pkg::EpsQ8);
    if (gu_q < 21'sd0) begin
      ox = '0;
    end else if (gu_q > XMax) begin
      ox = XMax[15:0];
    end else begin
      ox = gu_q[15:0];
    end
    if (gv_q < 21'sd0) begin
      oy = '0;
    end else if (gv_q > YMax) begin
      oy = YMax[15:0];
    end else begin
      oy = gv_q[15:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q <= 16'd16;
      fy_q <= 16'd16;
      cx_q <= '0;
      cy_q <= '0;
      k1_q <= '0;
      k2_q <= '0;
      p1_q <= '0;
      p2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        luip_pkg::CFG_FOCAL_X:   fx_q <= cfg_data_i[15:0];
        luip_pkg::CFG_FOCAL_Y:   fy_q <= cfg_data_i[15:0];
        luip_pkg::CFG_CENTER_X:  cx_q <= cfg_data_i[15:0];
        luip_pkg::CFG_CENTER_Y:  cy_q <= cfg_data_i[15:0];
        luip_pkg::CFG_RADIAL_K1: k1_q <= cfg_data_i;
        luip_pkg::CFG_RADIAL_K2: k2_q <= cfg_data_i;
        luip_pkg::CFG_TAN_P1:    p1_q <= cfg_data_i;
        luip_pkg::CFG_TAN_P2:    p2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_o.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (div_start) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_x_done && div_y_done) begin
            state_q <= S_PASS;
            step_q  <= ST_NX_LO;
            pass_q  <= '0;
          end
        end
        S_PASS: begin
          if (step_q == ST_CHECK) begin
            step_q <= ST_NX_LO;
            if (conv || pass_q == PassW'(MAX_ITERATIONS - 1)) begin
              state_q <= S_DONE;
            end else begin
              pass_q <= pass_q + 1'b1;
            end
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers: input capture, write-back of the previous product, output word
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      in_u_q <= in_i.payload.distorted_x;
      in_v_q <= in_i.payload.distorted_y;
    end
    if (state_q == S_DIV) begin
      gu_q <= $signed({5'b0, in_u_q});
      gv_q <= $signed({5'b0, in_v_q});
    end
    if (state_q == S_PASS) begin
      unique case (step_q)
        ST_NX_HI: acc_q <= prod[63:0];
        ST_NY_LO: x_q   <= norm;
        ST_NY_HI: acc_q <= prod[63:0];
        ST_X2:    y_q   <= norm;
        ST_Y2:    x2_q  <= mq;
        ST_XY: begin
          y2_q <= mq;
          r2_q <= luip_pkg::sat34(luip_pkg::sx34(x2_q) + luip_pkg::sx34(mq));
        end
        ST_R4:    txy_q <= luip_pkg::sat34(luip_pkg::sx34(mq) <<< 1);
        ST_K1:    r4_q  <= mq;
        ST_R6:    sum_q <= luip_pkg::sx34(luip_pkg::QOne) + luip_pkg::sx34(mq);
        ST_K2:    r6_q  <= mq;
        ST_K3:    sum_q <= sum_q + luip_pkg::sx34(mq);
        ST_XP1:   t_q   <= luip_pkg::sat34(sum_q + luip_pkg::sx34(mq));
        ST_XT:    sum_q <= luip_pkg::sx34(mq);
        ST_XP2:   sum_q <= sum_q + luip_pkg::sx34(mq);
        ST_YP2:   xd_q  <= luip_pkg::sat34(sum_q + luip_pkg::sx34(mq));
        ST_YT:    sum_q <= luip_pkg::sx34(mq);
        ST_YP1:   sum_q <= sum_q + luip_pkg::sx34(mq);
        ST_DU:    yd_q  <= luip_pkg::sat34(sum_q + luip_pkg::sx34(mq));
        ST_DV: begin
          ex_q <= res_c;
          gu_q <= g_c;
        end
        ST_EX2: begin
          ey_q <= res_c;
          gv_q <= g_c;
        end
        ST_EY2:   exsq_q <= prod[43:0];
        ST_CHECK: conv_q <= conv;
        default: ;
      endcase
    end
    // the output word may still be waiting, so it is loaded only here
    if (state_q == S_DONE && (!out_valid_q || out_o.ready)) begin
      out_q.corrected_x <= ox;
      out_q.corrected_y <= oy;
      out_q.converged   <= conv_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

/* hdl/luip_recip.sv */
// ----------------------------------------------------------------------------
// luip_recip
// Restoring divider forming floor(2^40 / divisor), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module luip_recip (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [luip_pkg::DivW-1:0]     divisor_i,
  output logic                          done_o,
  output logic [luip_pkg::RecipW-1:0]   quot_o
);

  localparam int CntW = $clog2(luip_pkg::RecipW);

  logic                         busy_q;
  logic [CntW-1:0]              cnt_q;
  logic [luip_pkg::DivW:0]      rem_q, rem_sh, rem_d;
  logic [luip_pkg::DivW-1:0]    div_q;
  logic [luip_pkg::RecipW-1:0]  quot_q;
  logic                         qbit;
  logic                         done_q;

  always_comb begin
    // dividend is a single one at the top bit
    rem_sh = {rem_q[luip_pkg::DivW-1:0],
              (cnt_q == CntW'(luip_pkg::RecipW - 1))};
    qbit   = (rem_sh >= {1'b0, div_q});
    rem_d  = qbit ? (rem_sh - {1'b0, div_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(luip_pkg::RecipW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[luip_pkg::RecipW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* hdl/luip_mul.sv */
// ----------------------------------------------------------------------------
// luip_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module luip_mul (
  input  logic                                clk_i,
  input  logic signed [luip_pkg::MulW-1:0]    a_i,
  input  logic signed [luip_pkg::MulW-1:0]    b_i,
  output logic signed [luip_pkg::ProdW-1:0]   p_o
);

  logic signed [luip_pkg::ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

/* hdl/luip_checker.sv */
// ----------------------------------------------------------------------------
// luip_checker
// Port-level checks for the lens undistortion block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lens_undistort_point_iterative_defines.svh"

module luip_checker #(
  parameter int IMAGE_WIDTH  = luip_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = luip_pkg::IMAGE_HEIGHT_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_x_i,
  input logic [15:0] out_y_i,
  input logic        out_conv_i
);

  localparam logic [15:0] XMax = 16'((IMAGE_WIDTH - 1) * 16);
  localparam logic [15:0] YMax = 16'((IMAGE_HEIGHT - 1) * 16);

  // one point in flight: taking a word closes the input
  `LUIP_ASSERT_CK(a_one_in_flight, in_valid_i && in_ready_i |=> !in_ready_i, "second word taken")

  // a result appears only after the input side was closed
  `LUIP_ASSERT_CK(a_result_after_work, $rose(out_valid_i) |-> !$past(in_ready_i), "early result")

  // results stay inside the image
  `LUIP_ASSERT_CK(a_in_image, out_valid_i |-> out_x_i <= XMax && out_y_i <= YMax, "result off image")

  `LUIP_ASSERT_CK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i) && $stable(out_y_i) && $stable(out_conv_i), "stalled word changed")

endmodule

bind lens_undistort_point_iterative luip_checker #(
  .IMAGE_WIDTH (IMAGE_WIDTH),
  .IMAGE_HEIGHT(IMAGE_HEIGHT)
) u_luip_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_x_i    (out_o.payload.corrected_x),
  .out_y_i    (out_o.payload.corrected_y),
  .out_conv_i (out_o.payload.converged)
);
